[src/sfd_pkg.sv]
// Shared types, constants and helper functions for the stereo feedback delay.
package sfd_pkg;

    localparam int SFD_LINE_DEPTH = 131072;
    localparam int SFD_Q_DEPTH    = 4;

    localparam logic [15:0] SFD_ONE  = 16'd32768;
    localparam logic [33:0] SFD_HALF = 34'd16384;

    localparam logic        SFD_RST_ENABLE = 1'b1;
    localparam logic [16:0] SFD_RST_DELAY  = 17'd12000;
    localparam logic [14:0] SFD_RST_FB     = 15'd11469;
    localparam logic [15:0] SFD_RST_MIX    = 16'd0;

    typedef enum logic [1:0] {
        CFG_ENABLE   = 2'd0,
        CFG_DELAY    = 2'd1,
        CFG_FEEDBACK = 2'd2,
        CFG_MIX      = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic s1_fwd_new;
        logic s1_fwd_old;
        logic s1_zero;
        logic s2_wen;
    } t_lane_ctl;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
    } t_pair;

    function automatic logic signed [15:0] sfd_sat(input logic signed [33:0] x);
        logic signed [15:0] y;
        if (x > 34'sd32767) begin
            y = 16'sh7fff;
        end else if (x < -34'sd32768) begin
            y = 16'sh8000;
        end else begin
            y = x[15:0];
        end
        return y;
    endfunction

    function automatic logic signed [33:0] sfd_round(input logic signed [33:0] x);
        logic signed [33:0] y;
        y = (x + $signed(SFD_HALF)) >>> 15;
        return y;
    endfunction

endpackage

[src/stereo_feedback_delay.sv]
// Stereo feedback delay: one stereo word in and one out per clock while i_stall is low.
// Each accepted word passes through the stage-1 and stage-2 lane registers into the output
// queue; the one-read, one-write port of each delay line memory sets the rate. Writes that
// are still in flight are forwarded to the read, so a delay of one or two samples needs no stall.
// Line entries not yet written since reset read as zero through a fill flag on the write
// index, so there is no clearing pass and the block accepts words right after reset. A
// four-word output queue holds results while the consumer stalls; o_stall rises only when
// the queue and the pipeline together hold four words.
module stereo_feedback_delay
    import sfd_pkg::*;
#(
    parameter int LINE_DEPTH = SFD_LINE_DEPTH,
    localparam int AW = $clog2(LINE_DEPTH)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_left_in,
    input  logic signed [15:0] i_right_in,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_left_out,
    output logic signed [15:0] o_right_out,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_addr,
    input  logic [16:0]        i_cfg_data
);

    localparam int CW = (AW + 1 > 17) ? AW + 1 : 17;

    logic          r_enable;
    logic [16:0]   r_delay;
    logic [14:0]   r_fb_gain;
    logic [15:0]   r_mix;

    logic [AW-1:0] r_wi;
    logic          r_full;
    logic          r1_valid;
    logic [AW-1:0] r1_rd;
    logic [AW-1:0] r1_wi;
    logic          r1_fwd_old;
    logic          r1_zero;
    logic          r2_valid;
    logic [AW-1:0] r2_wi;

    logic          accept;
    logic [CW-1:0] dl_ext;
    logic [CW-1:0] d_clamp;
    logic [AW-1:0] dd;
    logic [AW-1:0] rd;
    logic [AW-1:0] n_wi;
    logic [15:0]   mix_eff;
    logic [16:0]   mix_inv;
    logic [2:0]    q_level;
    logic [2:0]    pending;
    t_lane_ctl     ctl;
    logic signed [15:0] left_res;
    logic signed [15:0] right_res;

    assign pending = q_level + {2'd0, r1_valid} + {2'd0, r2_valid};
    assign o_stall = (pending > 3'd3);
    assign accept  = i_valid && !o_stall;

    assign dl_ext = CW'(r_delay);
    always_comb begin
        if (dl_ext == '0) begin
            d_clamp = CW'(1);
        end else if (dl_ext > CW'(LINE_DEPTH - 1)) begin
            d_clamp = CW'(LINE_DEPTH - 1);
        end else begin
            d_clamp = dl_ext;
        end
    end
    assign dd = d_clamp[AW-1:0];

    always_comb begin
        if (r_wi >= dd) begin
            rd = r_wi - dd;
        end else begin
            rd = AW'({1'b0, r_wi} + (AW + 1)'(LINE_DEPTH) - {1'b0, dd});
        end
    end

    assign n_wi    = (r_wi == AW'(LINE_DEPTH - 1)) ? '0 : r_wi + AW'(1);
    assign mix_eff = (r_mix > SFD_ONE) ? SFD_ONE : r_mix;
    assign mix_inv = {1'b0, SFD_ONE} - {1'b0, mix_eff};

    assign ctl.s1_fwd_new = r2_valid && (r2_wi == r1_rd);
    assign ctl.s1_fwd_old = r1_fwd_old;
    assign ctl.s1_zero    = r1_zero;
    assign ctl.s2_wen     = r2_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable  <= SFD_RST_ENABLE;
            r_delay   <= SFD_RST_DELAY;
            r_fb_gain <= SFD_RST_FB;
            r_mix     <= SFD_RST_MIX;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_ENABLE:   r_enable  <= i_cfg_data[0];
                CFG_DELAY:    r_delay   <= i_cfg_data;
                CFG_FEEDBACK: r_fb_gain <= i_cfg_data[14:0];
                CFG_MIX:      r_mix     <= i_cfg_data[15:0];
                default:      r_enable  <= r_enable;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wi     <= '0;
            r_full   <= 1'b0;
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else begin
            r1_valid <= accept;
            r2_valid <= r1_valid;
            if (accept) begin
                r_wi <= n_wi;
                if (r_wi == AW'(LINE_DEPTH - 1)) begin
                    r_full <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r1_rd      <= rd;
        r1_wi      <= r_wi;
        r1_fwd_old <= r2_valid && (r2_wi == rd);
        r1_zero    <= !(r_full || (rd < r_wi));
        r2_wi      <= r1_wi;
    end

    sfd_lane #(
        .LINE_DEPTH(LINE_DEPTH)
    ) u_lane_left (
        .i_clk     (i_clk),
        .i_rd_addr (rd),
        .i_wr_addr (r2_wi),
        .i_ctl     (ctl),
        .i_sample  (i_left_in),
        .i_fb_gain (r_fb_gain),
        .i_mix     (mix_eff),
        .i_mix_inv (mix_inv),
        .i_enable  (r_enable),
        .o_result  (left_res)
    );

    sfd_lane #(
        .LINE_DEPTH(LINE_DEPTH)
    ) u_lane_right (
        .i_clk     (i_clk),
        .i_rd_addr (rd),
        .i_wr_addr (r2_wi),
        .i_ctl     (ctl),
        .i_sample  (i_right_in),
        .i_fb_gain (r_fb_gain),
        .i_mix     (mix_eff),
        .i_mix_inv (mix_inv),
        .i_enable  (r_enable),
        .o_result  (right_res)
    );

    sfd_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r2_valid),
        .i_left  (left_res),
        .i_right (right_res),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_left  (o_left_out),
        .o_right (o_right_out),
        .o_level (q_level)
    );

endmodule

[src/sfd_lane.sv]
// One channel lane: delay line memory, feedback write path and dry/wet blend.
module sfd_lane
    import sfd_pkg::*;
#(
    parameter int LINE_DEPTH = SFD_LINE_DEPTH,
    localparam int AW = $clog2(LINE_DEPTH)
) (
    input  logic               i_clk,
    input  logic [AW-1:0]      i_rd_addr,
    input  logic [AW-1:0]      i_wr_addr,
    input  t_lane_ctl          i_ctl,
    input  logic signed [15:0] i_sample,
    input  logic [14:0]        i_fb_gain,
    input  logic [15:0]        i_mix,
    input  logic [16:0]        i_mix_inv,
    input  logic               i_enable,
    output logic signed [15:0] o_result
);

    logic [15:0] r_mem [LINE_DEPTH];
    logic [15:0] r_q;
    logic signed [15:0] r1_in;
    logic signed [15:0] r1_fwd_data;
    logic signed [15:0] r2_in;
    logic signed [33:0] r2_pfb;
    logic signed [33:0] r2_pin;
    logic signed [33:0] r2_pdl;

    logic signed [15:0] delayed;
    logic signed [15:0] w2_data;
    logic signed [33:0] n2_pfb;
    logic signed [33:0] n2_pin;
    logic signed [33:0] n2_pdl;
    logic signed [33:0] fb_round;
    logic signed [33:0] mix_round;

    always_comb begin
        if (i_ctl.s1_fwd_new) begin
            delayed = w2_data;
        end else if (i_ctl.s1_fwd_old) begin
            delayed = r1_fwd_data;
        end else if (i_ctl.s1_zero) begin
            delayed = 16'sd0;
        end else begin
            delayed = $signed(r_q);
        end
    end

    assign n2_pfb = 34'(delayed) * $signed({19'd0, i_fb_gain});
    assign n2_pdl = 34'(delayed) * $signed({18'd0, i_mix});
    assign n2_pin = 34'(r1_in) * $signed({17'd0, i_mix_inv});

    assign fb_round  = sfd_round(r2_pfb);
    assign w2_data   = sfd_sat(34'(r2_in) + fb_round);
    assign mix_round = sfd_round(r2_pin + r2_pdl);
    assign o_result  = i_enable ? sfd_sat(mix_round) : r2_in;

    always_ff @(posedge i_clk) begin
        if (i_ctl.s2_wen) begin
            r_mem[i_wr_addr] <= w2_data;
        end
        r_q         <= r_mem[i_rd_addr];
        r1_in       <= i_sample;
        r1_fwd_data <= w2_data;
        r2_in       <= r1_in;
        r2_pfb      <= n2_pfb;
        r2_pin      <= n2_pin;
        r2_pdl      <= n2_pdl;
    end

endmodule

[src/sfd_outq.sv]
// Output queue that merges the two lane results into one stereo word.
module sfd_outq
    import sfd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic signed [15:0] i_left,
    input  logic signed [15:0] i_right,
    input  logic               i_stall,
    output logic               o_valid,
    output logic signed [15:0] o_left,
    output logic signed [15:0] o_right,
    output logic [2:0]         o_level
);

    t_pair      r_buf [SFD_Q_DEPTH];
    logic [1:0] r_wr_ptr;
    logic [1:0] r_rd_ptr;
    logic [2:0] r_count;
    logic       pop;
    t_pair      head;

    assign o_valid = (r_count != 3'd0);
    assign pop     = o_valid && !i_stall;
    assign head    = r_buf[r_rd_ptr];
    assign o_left  = head.left;
    assign o_right = head.right;
    assign o_level = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= '{left: i_left, right: i_right};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_count  <= 3'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 2'd1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 3'd1;
                2'b01:   r_count <= r_count - 3'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[tb/sv/stereo_feedback_delay_tb.sv]
// Self-checking testbench for the stereo feedback delay, with echo prediction and random handshakes.
`timescale 1ns / 1ps

module stereo_feedback_delay_tb
    import sfd_pkg::*;
();

    class echo_checker;
        shortint     left_line[];
        shortint     right_line[];
        int unsigned wr_idx;
        logic        en;
        logic [16:0] delay;
        logic [14:0] fb_gain;
        logic [15:0] mix;
        t_pair       expected_pairs[$];
        int unsigned words_in;
        int unsigned words_out;
        int unsigned reg_writes;
        int unsigned errors;

        function new();
            left_line  = new[SFD_LINE_DEPTH];
            right_line = new[SFD_LINE_DEPTH];
            wr_idx     = 0;
            en         = SFD_RST_ENABLE;
            delay      = SFD_RST_DELAY;
            fb_gain    = SFD_RST_FB;
            mix        = SFD_RST_MIX;
            words_in   = 0;
            words_out  = 0;
            reg_writes = 0;
            errors     = 0;
        endfunction

        task report(input string msg);
            errors++;
            if (errors <= 50) begin
                $display("mismatch: %s", msg);
            end
        endtask

        function longint q15_round(input longint x);
            return (x + 64'sd16384) >>> 15;
        endfunction

        function shortint clip16(input longint x);
            if (x > 32767) begin
                return 16'sh7fff;
            end else if (x < -32768) begin
                return 16'sh8000;
            end
            return shortint'(x);
        endfunction

        function void write_reg(input t_cfg_idx idx, input logic [16:0] data);
            reg_writes++;
            case (idx)
                CFG_ENABLE:   en      = data[0];
                CFG_DELAY:    delay   = data;
                CFG_FEEDBACK: fb_gain = data[14:0];
                CFG_MIX:      mix     = data[15:0];
                default: ;
            endcase
        endfunction

        function void take_pair(input shortint l, input shortint r);
            int unsigned d;
            int unsigned rd;
            longint      li;
            longint      ri;
            longint      dl;
            longint      dr;
            longint      fbl;
            longint      wet;
            t_pair       p;
            d = delay;
            if (d < 1) d = 1;
            if (d > SFD_LINE_DEPTH - 1) d = SFD_LINE_DEPTH - 1;
            wet = (mix > 16'd32768) ? 32768 : longint'(mix);
            fbl = longint'(fb_gain);
            li  = l;
            ri  = r;
            rd  = (wr_idx + SFD_LINE_DEPTH - d) % SFD_LINE_DEPTH;
            dl  = left_line[rd];
            dr  = right_line[rd];
            left_line[wr_idx]  = clip16(li + q15_round(dl * fbl));
            right_line[wr_idx] = clip16(ri + q15_round(dr * fbl));
            if (en) begin
                p.left  = clip16(q15_round(li * (64'sd32768 - wet) + dl * wet));
                p.right = clip16(q15_round(ri * (64'sd32768 - wet) + dr * wet));
            end else begin
                p.left  = l;
                p.right = r;
            end
            wr_idx = (wr_idx + 1) % SFD_LINE_DEPTH;
            expected_pairs.push_back(p);
            words_in++;
        endfunction

        task check_pair(input logic signed [15:0] l, input logic signed [15:0] r);
            t_pair p;
            if (expected_pairs.size() == 0) begin
                report("result word arrived with no word pending");
            end else begin
                p = expected_pairs.pop_front();
                if (l !== p.left) begin
                    report($sformatf("word %0d left_out got %0d, predicted %0d",
                                     words_out, l, p.left));
                end
                if (r !== p.right) begin
                    report($sformatf("word %0d right_out got %0d, predicted %0d",
                                     words_out, r, p.right));
                end
            end
            words_out++;
        endtask

        function int unsigned pending();
            return expected_pairs.size();
        endfunction

        task leftover();
            report($sformatf("%0d predicted words never arrived", expected_pairs.size()));
            expected_pairs.delete();
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n     = 1'b0;
    logic               i_valid     = 1'b0;
    logic               o_stall;
    logic signed [15:0] i_left_in   = '0;
    logic signed [15:0] i_right_in  = '0;
    logic               o_valid;
    logic               i_stall     = 1'b0;
    logic signed [15:0] o_left_out;
    logic signed [15:0] o_right_out;
    logic               i_cfg_we    = 1'b0;
    logic [1:0]         i_cfg_addr  = '0;
    logic [16:0]        i_cfg_data  = '0;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    echo_checker sb;

    stereo_feedback_delay dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_left_in   (i_left_in),
        .i_right_in  (i_right_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_left_out  (o_left_out),
        .o_right_out (o_right_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("[stereo_feedback_delay] ERROR");
        $finish;
    end

    always @(posedge i_clk) begin
        i_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) begin
                sb.write_reg(t_cfg_idx'(i_cfg_addr), i_cfg_data);
            end
            if (i_valid && !o_stall) begin
                sb.take_pair(i_left_in, i_right_in);
            end
            if (o_valid && !i_stall) begin
                sb.check_pair(o_left_out, o_right_out);
            end
        end
    end

    function automatic shortint rand_sample();
        case ($urandom_range(7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return shortint'($urandom_range(64)) - 16'sd32;
            default: return shortint'($urandom);
        endcase
    endfunction

    task automatic send_word(input shortint l, input shortint r);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_left_in  <= l;
        i_right_in <= r;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
    endtask

    // Stops sending and waits until every predicted word has come back.
    task automatic drain();
        int unsigned waited;
        waited = 0;
        i_valid <= 1'b0;
        while (sb.pending() != 0 && waited < 4000) begin
            @(negedge i_clk);
            waited++;
        end
        if (sb.pending() != 0) begin
            sb.leftover();
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic put_reg(input t_cfg_idx idx, input logic [16:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    // The unused upper data bits are filled at random; each register must ignore them.
    task automatic set_config(input logic en, input logic [16:0] d, input logic [14:0] fb,
                              input logic [15:0] mx);
        logic [16:0] noise;
        noise = 17'($urandom);
        put_reg(CFG_ENABLE, {noise[16:1], en});
        put_reg(CFG_DELAY, d);
        put_reg(CFG_FEEDBACK, {noise[1:0], fb});
        put_reg(CFG_MIX, {noise[16], mx});
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_config();
        logic        en;
        logic [16:0] d;
        logic [14:0] fb;
        logic [15:0] mx;
        en = ($urandom_range(4) != 0);
        case ($urandom_range(5))
            0: d = 17'd1;
            1: d = 17'd0;
            2: d = 17'($urandom_range(2, 4));
            3: d = 17'($urandom_range(5, 400));
            4: d = 17'h1ffff;
            default: d = 17'($urandom);
        endcase
        case ($urandom_range(3))
            0: fb = 15'h7fff;
            1: fb = 15'd0;
            default: fb = 15'($urandom);
        endcase
        case ($urandom_range(4))
            0: mx = 16'd32768;
            1: mx = 16'hffff;
            2: mx = 16'd0;
            default: mx = 16'($urandom_range(32768));
        endcase
        set_config(en, d, fb, mx);
    endtask

    initial begin
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(16'sh7fff, 16'sh8000);
        send_word(16'sh8000, 16'sh7fff);
        send_word(16'sd0, 16'sd0);
        send_word(-16'sd1, 16'sd1);
        send_word(16'sd1, -16'sd1);
        send_word(16'sd16384, -16'sd16384);
        drain();

        // A zero delay acts as one; full feedback saturates the lines; the mix acts as fully wet.
        set_config(1'b1, 17'd0, 15'h7fff, 16'hffff);
        repeat (3) send_word(16'sh7fff, 16'sh7fff);
        repeat (3) send_word(16'sh8000, 16'sh8000);
        drain();

        set_config(1'b0, 17'd2, 15'd31130, 16'd32768);
        send_word(16'sd100, -16'sd100);
        send_word(16'sh7fff, 16'sh8000);
        send_word(16'sd0, 16'sd1);
        send_word(-16'sd1, 16'sd0);
        send_word(16'sd12345, -16'sd12345);
        drain();

        // A half mix of plus and minus one lands exactly on rounding ties.
        set_config(1'b1, 17'h1ffff, 15'd0, 16'd16384);
        send_word(16'sd1, 16'sd1);
        send_word(-16'sd1, -16'sd1);
        send_word(16'sh7fff, 16'sh7fff);
        send_word(16'sh8000, 16'sh8000);
        drain();

        for (int seg = 0; seg < 8; seg++) begin
            case (seg % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            random_config();
            for (int k = 0; k < 240; k++) begin
                if (k == 120) begin
                    drain();
                end
                send_word(rand_sample(), rand_sample());
            end
            drain();
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        drain();
        $display("Sent %0d stereo words, checked %0d results, made %0d register writes.",
                 sb.words_in, sb.words_out, sb.reg_writes);
        $display("Covered pass-through, dry to fully wet mixes, saturating feedback and delays.");
        if (sb.errors == 0) begin
            $display("[stereo_feedback_delay] OK");
        end else begin
            $display("[stereo_feedback_delay] ERROR");
        end
        $finish;
    end

endmodule
